/* design/sns_pkg.sv */
// Shared types and constants for the sorted node key shift store.
// No dependencies; used by sns_cell, sns_cell_row and sorted_node_key_shift_store.
package sns_pkg;

    // default node order and result limits
    localparam int MAX_KEYS_DEF = 15;
    localparam int MAX_RESULTS  = 16;
    localparam int POS_W        = 5;
    localparam int WORD_W       = 32;
    localparam int RES_CNT_W    = 5;

    // status codes carried with each result
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    // sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SPLICE = 2'b10
    } state_t;

    // per-cell load selection
    typedef struct packed {
        logic load_new;
        logic take_lower;
        logic take_upper;
    } cell_ctrl_t;

    // command from the sequencer to the cell row
    typedef struct packed {
        logic insert_en;
        logic shift_en;
    } row_cmd_t;

endpackage

/* design/sns_cell.sv */
// One storage cell of the node: a key and a data word.
// Depends on sns_pkg for the cell control struct and word width.
module sns_cell (
    input  logic                            aclk,
    input  sns_pkg::cell_ctrl_t             ctrl,
    input  logic [sns_pkg::WORD_W-1:0]      new_key,
    input  logic [sns_pkg::WORD_W-1:0]      new_data,
    input  logic [sns_pkg::WORD_W-1:0]      lower_key,
    input  logic [sns_pkg::WORD_W-1:0]      lower_data,
    input  logic [sns_pkg::WORD_W-1:0]      upper_key,
    input  logic [sns_pkg::WORD_W-1:0]      upper_data,
    output logic [sns_pkg::WORD_W-1:0]      key_q,
    output logic [sns_pkg::WORD_W-1:0]      data_q
);

    logic [sns_pkg::WORD_W-1:0] key_reg, key_next;
    logic [sns_pkg::WORD_W-1:0] data_reg, data_next;

    // pick the new entry, the lower neighbor or the upper neighbor
    always_comb begin
        key_next  = key_reg;
        data_next = data_reg;
        if (ctrl.load_new) begin
            key_next  = new_key;
            data_next = new_data;
        end else if (ctrl.take_lower) begin
            key_next  = lower_key;
            data_next = lower_data;
        end else if (ctrl.take_upper) begin
            key_next  = upper_key;
            data_next = upper_data;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign key_q  = key_reg;
    assign data_q = data_reg;

endmodule

/* design/sns_cell_row.sv */
// Row of storage cells that shift up on insert and down one place per step on splice.
// Depends on sns_pkg and sns_cell.
module sns_cell_row #(
    parameter int CAP   = sns_pkg::MAX_KEYS_DEF + 1,
    parameter int CMP_W = sns_pkg::POS_W
) (
    input  logic                            aclk,
    input  sns_pkg::row_cmd_t               cmd,
    input  logic [CMP_W-1:0]                start,
    input  logic [CMP_W-1:0]                count,
    input  logic [sns_pkg::WORD_W-1:0]      new_key,
    input  logic [sns_pkg::WORD_W-1:0]      new_data,
    output logic [sns_pkg::WORD_W-1:0]      head_key,
    output logic [sns_pkg::WORD_W-1:0]      head_data
);

    logic [sns_pkg::WORD_W-1:0] key_q  [CAP];
    logic [sns_pkg::WORD_W-1:0] data_q [CAP];

    // chain of cells with neighbor links
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        localparam logic [CMP_W-1:0] IDX     = CMP_W'(i);
        localparam logic [CMP_W-1:0] IDX_UP  = CMP_W'(i + 1);

        sns_pkg::cell_ctrl_t        ctrl;
        logic [sns_pkg::WORD_W-1:0] lower_key, lower_data;
        logic [sns_pkg::WORD_W-1:0] upper_key, upper_data;

        if (i == 0) begin : g_bottom
            assign lower_key  = '0;
            assign lower_data = '0;
        end else begin : g_lower
            assign lower_key  = key_q[i-1];
            assign lower_data = data_q[i-1];
        end

        if (i == CAP - 1) begin : g_top
            assign upper_key  = '0;
            assign upper_data = '0;
        end else begin : g_upper
            assign upper_key  = key_q[i+1];
            assign upper_data = data_q[i+1];
        end

        // insert opens a slot at start, splice closes the slot at start
        assign ctrl.load_new   = cmd.insert_en && (IDX == start);
        assign ctrl.take_lower = cmd.insert_en && (IDX > start) && (IDX <= count);
        assign ctrl.take_upper = cmd.shift_en && (IDX >= start) && (IDX_UP < count);

        sns_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .new_key    (new_key),
            .new_data   (new_data),
            .lower_key  (lower_key),
            .lower_data (lower_data),
            .upper_key  (upper_key),
            .upper_data (upper_data),
            .key_q      (key_q[i]),
            .data_q     (data_q[i])
        );
    end

    // entry at the start position, the one a splice step removes
    always_comb begin
        head_key  = '0;
        head_data = '0;
        for (int j = 0; j < CAP; j++) begin
            if (CMP_W'(j) == start) begin
                head_key  = head_key  | key_q[j];
                head_data = head_data | data_q[j];
            end
        end
    end

endmodule

/* design/sorted_node_key_shift_store.sv */
// Top level of the sorted node key shift store: stream ports, sequencer, result register.
// Depends on sns_pkg and sns_cell_row.
//
//  channel | direction | tdata fields (low bit up)                        | tuser / tlast
//  s_      | in        | position, end_position, key_value, data_value,   | tuser: kind
//          |           | return_removed (75 bits, padded to 80)           |
//  m_      | out       | removed_key, removed_data, count_after           | tuser: status,
//          |           | (69 bits, padded to 72)                          | removed_valid; tlast
//
// An insert, a rejected request or a bad splice range has its result in the cycle after accept.
// A valid splice takes end_position - position steps after accept, one cell shift per cycle
// along the cell row; each step emits one removed entry when return_removed is set.
// One transaction is in work at a time; a held result stalls the splice steps.
// aresetn clears the entry count and the sequencer; cell contents are undefined until written.
module sorted_node_key_shift_store #(
    parameter int MAX_KEYS = sns_pkg::MAX_KEYS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // position, end_position, key_value, data_value, return_removed
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // removed_key, removed_data, count_after
    output logic [2:0]  m_tuser,   // status, removed_valid
    output logic        m_tlast
);

    localparam int CAP   = MAX_KEYS + 1;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int PW    = sns_pkg::POS_W;
    localparam int WW    = sns_pkg::WORD_W;
    localparam int RW    = sns_pkg::RES_CNT_W;
    localparam int CMP_W = (CNT_W > PW) ? CNT_W : PW;

    // input fields
    logic          in_kind, in_want;
    logic [PW-1:0] in_pos_raw, in_end_raw;
    logic [WW-1:0] in_key, in_data;

    assign in_kind    = s_tuser;
    assign in_pos_raw = s_tdata[4:0];
    assign in_end_raw = s_tdata[9:5];
    assign in_key     = s_tdata[41:10];
    assign in_data    = s_tdata[73:42];
    assign in_want    = s_tdata[74];

    // sequencer and result registers
    sns_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remaining_reg, remaining_next;
    logic [CNT_W-1:0] final_reg, final_next;
    logic [CMP_W-1:0] start_reg, start_next;
    logic             want_reg, want_next;
    logic [RW-1:0]    emitted_reg, emitted_next;

    logic             out_valid_reg, out_valid_next;
    sns_pkg::status_t out_status_reg, out_status_next;
    logic             out_rvalid_reg, out_rvalid_next;
    logic [WW-1:0]    out_key_reg, out_key_next;
    logic [WW-1:0]    out_data_reg, out_data_next;
    logic [PW-1:0]    out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;

    logic             out_free, in_acc, step;
    logic [CMP_W-1:0] in_pos, in_end, count_ext, row_start, span;
    logic             is_full, ins_bad, spl_bad, ins_ok;
    sns_pkg::row_cmd_t row_cmd;
    logic [WW-1:0]    head_key, head_data;

    // handshake and request checks
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == sns_pkg::ST_IDLE) && out_free;
    assign in_acc    = s_tvalid && s_tready;
    assign step      = (state_reg == sns_pkg::ST_SPLICE) && out_free;

    assign in_pos    = CMP_W'(in_pos_raw);
    assign in_end    = CMP_W'(in_end_raw);
    assign count_ext = CMP_W'(count_reg);
    assign span      = in_end - in_pos;

    assign is_full   = count_reg >= CNT_W'(CAP);
    assign ins_bad   = in_pos > count_ext;
    assign spl_bad   = (in_end > count_ext) || (in_end <= in_pos);
    assign ins_ok    = in_acc && !in_kind && !is_full && !ins_bad;

    // cell row command
    assign row_cmd.insert_en = ins_ok;
    assign row_cmd.shift_en  = step;
    assign row_start = (state_reg == sns_pkg::ST_SPLICE) ? start_reg : in_pos;

    sns_cell_row #(
        .CAP   (CAP),
        .CMP_W (CMP_W)
    ) u_row (
        .aclk      (aclk),
        .cmd       (row_cmd),
        .start     (row_start),
        .count     (count_ext),
        .new_key   (in_key),
        .new_data  (in_data),
        .head_key  (head_key),
        .head_data (head_data)
    );

    // sequencer next state and result loading
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        remaining_next  = remaining_reg;
        final_next      = final_reg;
        start_next      = start_reg;
        want_next       = want_reg;
        emitted_next    = emitted_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_rvalid_next = out_rvalid_reg;
        out_key_next    = out_key_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            sns_pkg::ST_IDLE: begin
                if (in_acc) begin
                    out_valid_next  = 1'b1;
                    out_rvalid_next = 1'b0;
                    out_key_next    = '0;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_count_next  = PW'(count_ext);
                    if (!in_kind) begin
                        if (is_full) begin
                            out_status_next = sns_pkg::STATUS_FULL;
                        end else if (ins_bad) begin
                            out_status_next = sns_pkg::STATUS_BAD;
                        end else begin
                            out_status_next = sns_pkg::STATUS_OK;
                            count_next      = count_reg + CNT_W'(1);
                            out_count_next  = PW'(CMP_W'(count_reg + CNT_W'(1)));
                        end
                    end else if (spl_bad) begin
                        out_status_next = sns_pkg::STATUS_BAD;
                    end else begin
                        // valid splice: results come from the step cycles
                        out_valid_next = 1'b0;
                        start_next     = in_pos;
                        remaining_next = CNT_W'(span);
                        final_next     = count_reg - CNT_W'(span);
                        want_next      = in_want;
                        emitted_next   = '0;
                        state_next     = sns_pkg::ST_SPLICE;
                    end
                end
            end
            sns_pkg::ST_SPLICE: begin
                if (step) begin
                    count_next     = count_reg - CNT_W'(1);
                    remaining_next = remaining_reg - CNT_W'(1);
                    // removed entry, up to the result limit
                    if (want_reg && (emitted_reg < RW'(sns_pkg::MAX_RESULTS))) begin
                        out_valid_next  = 1'b1;
                        out_status_next = sns_pkg::STATUS_OK;
                        out_rvalid_next = 1'b1;
                        out_key_next    = head_key;
                        out_data_next   = head_data;
                        out_count_next  = PW'(CMP_W'(final_reg));
                        out_last_next   = (remaining_reg == CNT_W'(1)) ||
                                          (emitted_reg == RW'(sns_pkg::MAX_RESULTS - 1));
                        emitted_next    = emitted_reg + RW'(1);
                    end
                    if (remaining_reg == CNT_W'(1)) begin
                        state_next = sns_pkg::ST_IDLE;
                        // single summary result when removed entries are discarded
                        if (!want_reg) begin
                            out_valid_next  = 1'b1;
                            out_status_next = sns_pkg::STATUS_OK;
                            out_rvalid_next = 1'b0;
                            out_key_next    = '0;
                            out_data_next   = '0;
                            out_count_next  = PW'(CMP_W'(final_reg));
                            out_last_next   = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = sns_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sns_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and per-transaction bookkeeping
    always_ff @(posedge aclk) begin
        remaining_reg  <= remaining_next;
        final_reg      <= final_next;
        start_reg      <= start_next;
        want_reg       <= want_next;
        emitted_reg    <= emitted_next;
        out_status_reg <= out_status_next;
        out_rvalid_reg <= out_rvalid_next;
        out_key_reg    <= out_key_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_data_reg, out_key_reg};
    assign m_tuser  = {out_rvalid_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // a result without a removed entry always closes its transaction
    a_plain_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_rvalid_reg) |-> out_last_reg)
        else $error("result without removed entry not marked last");

    // removed entries only come with ok status
    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_rvalid_reg) |-> (out_status_reg == sns_pkg::STATUS_OK))
        else $error("removed entry with error status");

    // entry count never exceeds the node capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAP))
        else $error("entry count above capacity");

    // a splice in progress always has steps left
    a_splice_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sns_pkg::ST_SPLICE) |-> (remaining_reg != '0))
        else $error("splice state with no steps left");

    // a step lowers the count by one
    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("splice step did not lower the count");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_node_key_shift_store: directed table, then random node updates.
// Depends on sns_pkg and the design; predicts untyped results with its own copy of the node.

module testbench;

    localparam int NODE_CAP       = sns_pkg::MAX_KEYS_DEF + 1;
    localparam int RANDOM_OPS     = 254;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SPLICE = 1'b1
    } node_op_t;

    typedef struct packed {
        node_op_t    op;
        logic [4:0]  pos;
        logic [4:0]  stop;
        logic [31:0] key;
        logic [31:0] data;
        logic        ret;
    } node_req_t;

    typedef struct packed {
        sns_pkg::status_t status;
        logic             rvalid;
        logic [31:0]      rkey;
        logic [31:0]      rdata;
        logic [4:0]       cnt;
        logic             last;
    } node_res_t;

    // one row of the directed table; typed rows carry their single result by hand
    typedef struct packed {
        node_req_t        req;
        logic             typed;
        sns_pkg::status_t t_status;
        logic [4:0]       t_count;
    } step_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // position, end_position, key_value, data_value, return_removed
    logic        s_tuser  = 1'b0; // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // removed_key, removed_data, count_after
    logic [2:0]  m_tuser;         // status, removed_valid
    logic        m_tlast;

    // predictor copy of the node
    logic [31:0] node_keys [NODE_CAP];
    logic [31:0] node_data [NODE_CAP];
    int          node_count;

    node_res_t   step_results [$];
    node_res_t   pending_results [$];
    step_row_t   directed_steps [$];
    int          error_count  = 0;
    int          stall_cycles = 0;
    int          burst_left   = 0;
    bit          hold_request = 1'b0;

    sorted_node_key_shift_store dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // node update as the block should perform it; results land in step_results
    task automatic apply_node_op(input node_req_t rq);
        int          len;
        logic [31:0] cut_keys [NODE_CAP];
        logic [31:0] cut_data [NODE_CAP];
        node_res_t   r;
        step_results.delete();
        r        = '0;
        r.last   = 1'b1;
        r.status = sns_pkg::STATUS_OK;
        if (rq.op == OP_INSERT) begin
            if (node_count >= NODE_CAP) begin
                r.status = sns_pkg::STATUS_FULL;
            end else if (rq.pos > node_count) begin
                r.status = sns_pkg::STATUS_BAD;
            end else begin
                for (int i = node_count; i > rq.pos; i--) begin
                    node_keys[i] = node_keys[i - 1];
                    node_data[i] = node_data[i - 1];
                end
                node_keys[rq.pos] = rq.key;
                node_data[rq.pos] = rq.data;
                node_count++;
            end
            r.cnt = node_count[4:0];
            step_results.push_back(r);
        end else if (rq.stop > node_count || rq.stop <= rq.pos) begin
            r.status = sns_pkg::STATUS_BAD;
            r.cnt    = node_count[4:0];
            step_results.push_back(r);
        end else begin
            len = rq.stop - rq.pos;
            for (int i = 0; i < len; i++) begin
                cut_keys[i] = node_keys[rq.pos + i];
                cut_data[i] = node_data[rq.pos + i];
            end
            for (int i = rq.pos; i + len < node_count; i++) begin
                node_keys[i] = node_keys[i + len];
                node_data[i] = node_data[i + len];
            end
            node_count -= len;
            r.cnt = node_count[4:0];
            if (!rq.ret) begin
                step_results.push_back(r);
            end else begin
                // removed entries come out in ascending position order
                for (int n = 0; n < len; n++) begin
                    r.rvalid = 1'b1;
                    r.rkey   = cut_keys[n];
                    r.rdata  = cut_data[n];
                    r.last   = (n + 1 == len);
                    step_results.push_back(r);
                end
            end
        end
    endtask

    function automatic logic [79:0] pack_req(input node_req_t rq);
        return {5'b0, rq.ret, rq.data, rq.key, rq.stop, rq.pos};
    endfunction

    task automatic add_step(input node_op_t op, input int pos, input int stop,
                            input logic [31:0] key, input logic [31:0] data, input logic ret,
                            input logic typed, input sns_pkg::status_t t_status,
                            input int t_count);
        step_row_t row;
        row.req      = '{op: op, pos: pos[4:0], stop: stop[4:0], key: key, data: data, ret: ret};
        row.typed    = typed;
        row.t_status = t_status;
        row.t_count  = t_count[4:0];
        directed_steps.push_back(row);
    endtask

    // directed table: empty-node errors, fill to capacity, full and range errors, full splice
    task automatic build_directed();
        int fill_pos [16] = '{0, 1, 0, 3, 2, 5, 0, 7, 4, 9, 10, 6, 12, 13, 1, 15};
        add_step(OP_SPLICE, 0, 1, 32'h0, 32'h0, 1'b1, 1'b1, sns_pkg::STATUS_BAD, 0);
        add_step(OP_INSERT, 1, 0, 32'h1234_5678, 32'h9abc_def0, 1'b0, 1'b1,
                 sns_pkg::STATUS_BAD, 0);
        add_step(OP_INSERT, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1,
                 sns_pkg::STATUS_OK, 1);
        add_step(OP_INSERT, 1, 0, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1,
                 sns_pkg::STATUS_OK, 2);
        add_step(OP_INSERT, 0, 31, 32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b1,
                 sns_pkg::STATUS_OK, 3);
        add_step(OP_INSERT, 3, 0, 32'h0000_0000, 32'hffff_ffff, 1'b0, 1'b1,
                 sns_pkg::STATUS_OK, 4);
        for (int i = 4; i < 16; i++) begin
            add_step(OP_INSERT, fill_pos[i], 0, 32'h1000_0000 * i + 32'h55, ~(32'h0101 * i),
                     1'b0, 1'b1, sns_pkg::STATUS_OK, i + 1);
        end
        // node holds its capacity now
        add_step(OP_INSERT, 0, 0, 32'hdead_beef, 32'hcafe_f00d, 1'b0, 1'b1,
                 sns_pkg::STATUS_FULL, 16);
        add_step(OP_INSERT, 16, 0, 32'h0, 32'h0, 1'b0, 1'b1, sns_pkg::STATUS_FULL, 16);
        add_step(OP_SPLICE, 16, 16, 32'h0, 32'h0, 1'b1, 1'b1, sns_pkg::STATUS_BAD, 16);
        add_step(OP_SPLICE, 3, 2, 32'h0, 32'h0, 1'b1, 1'b1, sns_pkg::STATUS_BAD, 16);
        add_step(OP_SPLICE, 0, 16, 32'h0, 32'h0, 1'b1, 1'b0, sns_pkg::STATUS_OK, 0);
        add_step(OP_INSERT, 0, 0, 32'h0000_0001, 32'h0000_0002, 1'b0, 1'b1,
                 sns_pkg::STATUS_OK, 1);
        add_step(OP_INSERT, 0, 0, 32'hffff_fffe, 32'hffff_fffd, 1'b0, 1'b1,
                 sns_pkg::STATUS_OK, 2);
        add_step(OP_SPLICE, 0, 2, 32'h0, 32'h0, 1'b0, 1'b1, sns_pkg::STATUS_OK, 0);
    endtask

    // well-formed node updates most of the time, malformed requests now and then
    function automatic node_req_t random_req();
        node_req_t rq;
        int        ins_pct;
        int        len;
        rq.key  = $urandom;
        rq.data = $urandom;
        rq.ret  = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) < 8) begin
            rq.op   = node_op_t'($urandom_range(0, 1));
            rq.pos  = 5'($urandom_range(0, 31));
            rq.stop = 5'($urandom_range(0, 31));
            return rq;
        end
        ins_pct = (node_count < 3) ? 85 : (node_count >= 14) ? 30 : 55;
        if (node_count == 0 || $urandom_range(0, 99) < ins_pct) begin
            rq.op   = OP_INSERT;
            rq.pos  = 5'($urandom_range(0, node_count));
            rq.stop = 5'($urandom_range(0, 31));
        end else begin
            rq.op = OP_SPLICE;
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, node_count);
            else
                len = $urandom_range(1, (node_count < 4) ? node_count : 4);
            rq.pos  = 5'($urandom_range(0, node_count - len));
            rq.stop = 5'(int'(rq.pos) + len);
        end
        return rq;
    endfunction

    // sender idle gap: mostly none, some short, a few long, with gap-free bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = 30;
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one transaction, predict its results once accepted
    task automatic issue(input node_req_t rq, input logic typed,
                         input sns_pkg::status_t t_status, input logic [4:0] t_count);
        node_res_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= pack_req(rq);
        s_tuser  <= rq.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_node_op(rq);
        if (typed) begin
            r        = '0;
            r.status = t_status;
            r.cnt    = t_count;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic idle_sender(input bit drain);
        int gap;
        gap = pick_gap();
        if (drain) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (pending_results.size() != 0);
        end else if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stimulus
    initial begin
        step_row_t row;
        node_count = 0;
        build_directed();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_steps[i]) begin
            row = directed_steps[i];
            issue(row.req, row.typed, row.t_status, row.t_count);
            idle_sender(1'b0);
        end
        // receiver stalls while the sender keeps offering
        hold_request = 1'b1;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            issue(random_req(), 1'b0, sns_pkg::STATUS_OK, 5'd0);
            idle_sender(n == RANDOM_OPS / 2);
        end
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result-side backpressure
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else if ($urandom_range(0, 99) < 8) begin
                m_tready <= 1'b1;
                repeat (40) @(posedge aclk);
            end else if ($urandom_range(0, 99) < 65) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 99) < 85)
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                else
                    repeat ($urandom_range(8, 25)) @(posedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        node_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, key", m_tdata[31:0], 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[1:0] !== want.status)
                    report_mismatch("status", {30'h0, m_tuser[1:0]}, {30'h0, want.status});
                if (m_tuser[2] !== want.rvalid)
                    report_mismatch("removed_valid", {31'h0, m_tuser[2]}, {31'h0, want.rvalid});
                if (m_tdata[31:0] !== want.rkey)
                    report_mismatch("removed_key", m_tdata[31:0], want.rkey);
                if (m_tdata[63:32] !== want.rdata)
                    report_mismatch("removed_data", m_tdata[63:32], want.rdata);
                if (m_tdata[68:64] !== want.cnt)
                    report_mismatch("count_after", {27'h0, m_tdata[68:64]}, {27'h0, want.cnt});
                if (m_tlast !== want.last)
                    report_mismatch("last", {31'h0, m_tlast}, {31'h0, want.last});
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
